@@ design/strong_probable_prime_test_top_defines.svh @@
// Assertion macros shared by the checker
`ifndef STRONG_PROBABLE_PRIME_TEST_TOP_DEFINES_SVH
`define STRONG_PROBABLE_PRIME_TEST_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SPP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
// next-cycle implication
`define SPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// Widths and shared types of the strong probable prime test.
// ----------------------------------------------------------------------------
package spp_pkg;
  localparam int WordBits  = 64;
  localparam int NumWords  = 3;
  localparam int TotalBits = WordBits * NumWords;
  localparam int IdxBits   = $clog2(TotalBits + 1);

  typedef logic [TotalBits-1:0] big_t;
  typedef logic [IdxBits-1:0]   idx_t;
endpackage

@@ design/strong_probable_prime_test_top.sv @@
// ----------------------------------------------------------------------------
// strong_probable_prime_test_top
// Miller-Rabin test to one base on a modulus of up to 192 bits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)
//  in_     | in  | modulus_low, modulus_mid, modulus_high, base_low, base_mid,
//          |     | base_high (384 bits)
//  out_    | out | probable_prime, bad_modulus (tdata 8 bits)
// Each product is formed in the bit-serial multiplier; a test reduces the
// base, strips the trailing zeros of k, finds its top bit, then squares and
// multiplies over k and squares up to l - 1 more times.
// Bad moduli and a modulus of one go straight to the result.
// Reset is synchronous, active low; one transaction is in work at a time and
// in_tready stays low until the result is taken.
// ----------------------------------------------------------------------------
module strong_probable_prime_test_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // modulus_low, modulus_mid, modulus_high, base_low, base_mid, base_high
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // probable_prime, bad_modulus, zero fill
  output logic [7:0]   out_tdata
);
  import spp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_FIND = 4'd2, S_SQ = 4'd3,
                         S_MUL = 4'd4, S_CHK = 4'd5, S_LSQ = 4'd6, S_OUT = 4'd7,
                         S_LCHK = 4'd8;

  logic [3:0] st_r, st_nxt;
  big_t m_r, m_nxt, b_r, b_nxt, x_r, x_nxt, k_r, k_nxt, bin_r, bin_nxt;
  idx_t i_r, i_nxt, l_r, l_nxt;
  logic pp_r, pp_nxt, bad_r, bad_nxt;
  logic mstart;
  big_t ma, mb, mr;
  logic mdone;
  big_t mm1;
  logic [TotalBits:0] rsh;

  assign mm1 = m_r - big_t'(1);

  spp_mulmod u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .m(m_r),
                    .r(mr), .done(mdone));

  always_comb begin
    st_nxt = st_r; m_nxt = m_r; b_nxt = b_r; x_nxt = x_r; k_nxt = k_r;
    bin_nxt = bin_r; i_nxt = i_r; l_nxt = l_r; pp_nxt = pp_r; bad_nxt = bad_r;
    mstart = 1'b0; ma = x_r; mb = x_r;
    rsh = {b_r, bin_r[TotalBits-1]};
    if (rsh >= {1'b0, m_r}) rsh = rsh - {1'b0, m_r};
    unique case (st_r)
      S_IDLE: if (in_tvalid) begin
        m_nxt = in_tdata[TotalBits-1:0];
        bin_nxt = in_tdata[383:192];
        b_nxt = '0; i_nxt = idx_t'(TotalBits); l_nxt = '0; pp_nxt = 1'b0;
        bad_nxt = 1'b0;
        k_nxt = in_tdata[TotalBits-1:0] - big_t'(1);
        if (!in_tdata[0]) begin bad_nxt = 1'b1; st_nxt = S_OUT; end
        else if (in_tdata[TotalBits-1:0] == big_t'(1)) st_nxt = S_OUT;
        else st_nxt = S_RED;
      end
      S_RED: begin
        // one base bit per cycle; also strip one trailing zero of k while k is even
        b_nxt = rsh[TotalBits-1:0];
        bin_nxt = {bin_r[TotalBits-2:0], 1'b0};
        if (!k_r[0]) begin k_nxt = k_r >> 1; l_nxt = l_r + 1'b1; end
        i_nxt = i_r - 1'b1;
        if (i_r == idx_t'(1)) begin st_nxt = S_FIND; i_nxt = idx_t'(TotalBits - 1); end
      end
      S_FIND: begin
        if (!k_r[0]) begin k_nxt = k_r >> 1; l_nxt = l_r + 1'b1; end
        else if (k_r[i_r[7:0]]) begin
          x_nxt = b_r;
          if (i_r == '0) st_nxt = S_CHK;
          else begin
            i_nxt = i_r - 1'b1; st_nxt = S_SQ; mstart = 1'b1; ma = b_r; mb = b_r;
          end
        end else i_nxt = i_r - 1'b1;
      end
      S_SQ: if (mdone) begin
        x_nxt = mr;
        if (k_r[i_r[7:0]]) begin st_nxt = S_MUL; mstart = 1'b1; ma = mr; mb = b_r; end
        else if (i_r == '0) st_nxt = S_CHK;
        else begin i_nxt = i_r - 1'b1; mstart = 1'b1; ma = mr; mb = mr; end
      end
      S_MUL: begin
        mb = b_r;
        if (mdone) begin
          x_nxt = mr;
          if (i_r == '0) st_nxt = S_CHK;
          else begin i_nxt = i_r - 1'b1; st_nxt = S_SQ; mstart = 1'b1; ma = mr; mb = mr; end
        end
      end
      S_CHK: begin
        i_nxt = idx_t'(1);
        if (x_r == big_t'(1) || x_r == mm1) begin pp_nxt = 1'b1; st_nxt = S_OUT; end
        else st_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (i_r >= l_r) st_nxt = S_OUT;
        else begin mstart = 1'b1; st_nxt = S_LSQ; end
      end
      S_LSQ: if (mdone) begin
        x_nxt = mr; i_nxt = i_r + 1'b1;
        if (mr == mm1) begin pp_nxt = 1'b1; st_nxt = S_OUT; end
        else st_nxt = S_LCHK;
      end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    m_r <= m_nxt; b_r <= b_nxt; x_r <= x_nxt; k_r <= k_nxt; bin_r <= bin_nxt;
    i_r <= i_nxt; l_r <= l_nxt; pp_r <= pp_nxt; bad_r <= bad_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {6'b0, bad_r, pp_r};
endmodule

@@ design/spp_mulmod.sv @@
// ----------------------------------------------------------------------------
// spp_mulmod
// Bit-serial modular multiplier: r = a*b mod m, one multiplier bit per cycle,
// two conditional subtracts per step.
// ----------------------------------------------------------------------------
module spp_mulmod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  spp_pkg::big_t a,
  input  spp_pkg::big_t b,
  input  spp_pkg::big_t m,
  output spp_pkg::big_t r,
  output logic          done
);
  import spp_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  idx_t             cnt_r, cnt_nxt;
  logic [TotalBits:0] acc_r, acc_nxt;
  big_t             bsh_r, bsh_nxt;
  logic [TotalBits+1:0] t1, t2, t3;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    bsh_nxt  = bsh_r;
    t1 = {acc_r, 1'b0};
    if (t1 >= {2'b0, m}) t1 = t1 - {2'b0, m};
    t2 = t1 + (bsh_r[TotalBits-1] ? {2'b0, a} : '0);
    t3 = t2;
    if (t3 >= {2'b0, m}) t3 = t3 - {2'b0, m};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = idx_t'(TotalBits);
      acc_nxt  = '0;
      bsh_nxt  = b;
    end else if (busy_r) begin
      acc_nxt = t3[TotalBits:0];
      bsh_nxt = {bsh_r[TotalBits-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == idx_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    bsh_r <= bsh_nxt;
  end

  assign r    = acc_r[TotalBits-1:0];
  assign done = done_r;
endmodule

@@ design/spp_checker.sv @@
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks of the strong probable prime test.
// ----------------------------------------------------------------------------
`include "strong_probable_prime_test_top_defines.svh"
module spp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  `SPP_ASSERT_IMP(a_excl, out_tvalid, !in_tready)
  `SPP_ASSERT_IMP(a_flags, out_tvalid, !(out_tdata[0] && out_tdata[1]))
  `SPP_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SPP_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready)
endmodule

bind strong_probable_prime_test_top spp_checker u_chk (.*);
